/* hw/rtl/mmaa_pkg.sv */
`default_nettype none
package mmaa_pkg;

	// Fixed field widths
	localparam int unsigned LANES  = 8;
	localparam int unsigned VAL_W  = 16;
	localparam int unsigned ACC_W  = 64;
	localparam int unsigned COL_W  = 10;
	localparam int unsigned SEL_W  = 3;
	localparam int unsigned OP_W   = 3;
	localparam int unsigned CFG_AW = 2;
	localparam int unsigned MOD_W  = VAL_W + 1;

	// Remainder unit: bits per cycle and cycle count for a 64-bit entry
	localparam int unsigned RED_BITS  = 4;
	localparam int unsigned RED_CYC   = ACC_W / RED_BITS;
	localparam int unsigned RED_CNT_W = $clog2(RED_CYC);

	localparam logic [VAL_W-1:0] MODULUS_RST = 16'd65521;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR    = 3'd0,
		OP_SET_COEF = 3'd1,
		OP_LOAD     = 3'd2,
		OP_ACC      = 3'd3,
		OP_EMIT     = 3'd4
	} opcode_t;

	typedef enum logic [CFG_AW-1:0] {
		REG_MODULUS = 2'd0,
		REG_REDUCE  = 2'd1
	} cfg_reg_t;

	// Write data source for a lane memory
	typedef enum logic [1:0] {
		WSEL_ZERO  = 2'd0,
		WSEL_VALUE = 2'd1,
		WSEL_SUM   = 2'd2
	} wsel_t;

	// Per-cycle lane control from the sequencer
	typedef struct packed {
		logic  mem_we;
		wsel_t wsel;
		logic  rd_en;
		logic  red_load;
		logic  red_from_mem;
		logic  red_step;
		logic  coef_we;
	} lane_ctrl_t;

endpackage
`default_nettype wire

/* hw/rtl/mmaa_if.sv */
`default_nettype none
interface mmaa_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [9:0]  in_column;
	logic [2:0]  line_select;
	logic [15:0] value_0;
	logic [15:0] value_1;
	logic [15:0] value_2;
	logic [15:0] value_3;
	logic [15:0] value_4;
	logic [15:0] value_5;
	logic [15:0] value_6;
	logic [15:0] value_7;
	modport source (output valid, opcode, in_column, line_select, value_0, value_1, value_2,
		value_3, value_4, value_5, value_6, value_7, input ready);
	modport sink (input valid, opcode, in_column, line_select, value_0, value_1, value_2,
		value_3, value_4, value_5, value_6, value_7, output ready);
endinterface

interface mmaa_rsp_if;
	logic        valid;
	logic        ready;
	logic [9:0]  out_column;
	logic [15:0] result_0;
	logic [15:0] result_1;
	logic [15:0] result_2;
	logic [15:0] result_3;
	logic [15:0] result_4;
	logic [15:0] result_5;
	logic [15:0] result_6;
	logic [15:0] result_7;
	modport source (output valid, out_column, result_0, result_1, result_2, result_3,
		result_4, result_5, result_6, result_7, input ready);
	modport sink (input valid, out_column, result_0, result_1, result_2, result_3,
		result_4, result_5, result_6, result_7, output ready);
endinterface

interface mmaa_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  addr;
	logic [15:0] data;
	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/mmaa_ram.sv */
`default_nettype none
module mmaa_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 1024
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/mmaa_lane.sv */
`default_nettype none
module mmaa_lane #(
	parameter int unsigned COLS = 1024
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire mmaa_pkg::lane_ctrl_t   ctrl,
	input  wire [$clog2(COLS)-1:0]      addr,
	input  wire [mmaa_pkg::VAL_W-1:0]   value,
	input  wire [mmaa_pkg::VAL_W-1:0]   sel_value,
	input  wire [mmaa_pkg::MOD_W-1:0]   p_eff,
	input  wire                         reduce_en,
	output logic [mmaa_pkg::VAL_W-1:0]  result,
	output logic                        nonzero
);
	import mmaa_pkg::*;

	logic [ACC_W-1:0]   rdata;
	logic [ACC_W-1:0]   wdata;
	logic [VAL_W-1:0]   coef_q;
	logic [2*VAL_W-1:0] prod_s1;
	logic [ACC_W-1:0]   shift_q;
	logic [MOD_W-1:0]   rem_q;
	logic [VAL_W-1:0]   raw_low_q;
	logic               raw_nz_q;
	logic [ACC_W-1:0]   red_src;
	logic [ACC_W-1:0]   shift_nx;
	logic [MOD_W-1:0]   rem_nx;

	mmaa_ram #(.WIDTH(ACC_W), .DEPTH(COLS)) u_ram (
		.clk   (clk),
		.we    (ctrl.mem_we),
		.waddr (addr),
		.wdata (wdata),
		.re    (ctrl.rd_en),
		.raddr (addr),
		.rdata (rdata)
	);

	// Write data select
	always_comb begin
		case (ctrl.wsel)
			WSEL_ZERO:  wdata = '0;
			WSEL_VALUE: wdata = ACC_W'(value);
			WSEL_SUM:   wdata = rdata + ACC_W'(prod_s1);
			default:    wdata = '0;
		endcase
	end

	// Product taken alongside the memory read
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			prod_s1 <= coef_q * sel_value;
		end
	end

	// Remainder unit, RED_BITS dividend bits per cycle
	always_comb begin
		rem_nx   = rem_q;
		shift_nx = shift_q;
		for (int k = 0; k < RED_BITS; k++) begin
			rem_nx   = {rem_nx[MOD_W-2:0], shift_nx[ACC_W-1]};
			shift_nx = {shift_nx[ACC_W-2:0], 1'b0};
			if (rem_nx >= p_eff) begin
				rem_nx = rem_nx - p_eff;
			end
		end
	end

	assign red_src = ctrl.red_from_mem ? rdata : ACC_W'(value);

	always_ff @(posedge clk) begin
		if (ctrl.red_load) begin
			shift_q   <= red_src;
			rem_q     <= '0;
			raw_low_q <= red_src[VAL_W-1:0];
			raw_nz_q  <= (red_src != '0);
		end else if (ctrl.red_step) begin
			shift_q <= shift_nx;
			rem_q   <= rem_nx;
		end
	end

	// Coefficient stored as the negation mod p
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (ctrl.coef_we) begin
			coef_q <= (rem_q == '0) ? '0 : VAL_W'(p_eff - rem_q);
		end
	end

	assign result  = reduce_en ? rem_q[VAL_W-1:0] : raw_low_q;
	assign nonzero = reduce_en ? (rem_q != '0) : raw_nz_q;
endmodule
`default_nettype wire

/* hw/rtl/multiline_modular_axpy_accumulator.sv */
// Multiline modular axpy accumulator.
// cmd carries one request: opcode, column, line select and eight lane values.
// rsp carries one emitted column (out_column, result_0..7); it only appears
// for an emit whose column holds a nonzero entry. cfg writes modulus (0) and
// reduce_on_emit (1) and is always ready; write it only while idle.
// One request is worked at a time; cmd.ready is high in the idle state.
// Steps per request, set by the lane memories and the per-lane remainder
// unit (4 bits per cycle over a 64-bit entry):
//   load (write on request), accumulate (read, then add and write back),
//   set coefficients (load, reduce, write), emit (read, load, reduce, then
//   output once the register is free), clear (one column of all lanes per cycle).
// After reset the block runs the same clearing pass before cmd.ready
// rises; cfg writes are taken during it.
// The output register holds a result until rsp.ready; the block keeps
// taking requests meanwhile and only an emit that finishes while the
// register is still full waits.
`default_nettype none
module multiline_modular_axpy_accumulator #(
	parameter int unsigned LINES = 8,
	parameter int unsigned COLS  = 1024
) (
	input wire          clk,
	input wire          arst_n,
	mmaa_cmd_if.sink    cmd,
	mmaa_rsp_if.source  rsp,
	mmaa_cfg_if.sink    cfg
);
	import mmaa_pkg::*;

	localparam int unsigned AW = $clog2(COLS);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_CLEAR   = 8'b0000_0010,
		S_ACC_WR  = 8'b0000_0100,
		S_EM_LD   = 8'b0000_1000,
		S_EM_RED  = 8'b0001_0000,
		S_EM_OUT  = 8'b0010_0000,
		S_COEF    = 8'b0100_0000,
		S_COEF_WR = 8'b1000_0000
	} state_t;

	state_t                       state_q;
	logic [AW-1:0]                clr_cnt_q;
	logic [RED_CNT_W-1:0]         red_cnt_q;
	logic [AW-1:0]                addr_q;
	logic [COL_W-1:0]             col_q;
	logic [VAL_W-1:0]             modulus_q;
	logic                         reduce_q;
	logic [MOD_W-1:0]             p_eff;
	logic                         rsp_valid_q;
	logic [COL_W-1:0]             rsp_col_q;
	logic [LANES-1:0][VAL_W-1:0]  rsp_res_q;
	logic [LANES-1:0][VAL_W-1:0]  val;
	logic [LANES-1:0][VAL_W-1:0]  lane_res;
	logic [LANES-1:0]             lane_nz;
	logic [VAL_W-1:0]             sel_value;
	logic [AW-1:0]                cmd_addr;
	logic [AW-1:0]                mem_addr;
	logic                         cmd_fire;
	logic                         col_ok;
	logic                         sel_ok;
	logic                         emit_load;
	logic                         any_nz;
	lane_ctrl_t                   ctrl;

	assign val = {cmd.value_7, cmd.value_6, cmd.value_5, cmd.value_4,
		cmd.value_3, cmd.value_2, cmd.value_1, cmd.value_0};
	assign sel_value = val[cmd.line_select];

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign col_ok    = (32'(cmd.in_column) < COLS);
	assign sel_ok    = (32'(cmd.line_select) < LINES);
	assign cmd_addr  = AW'(cmd.in_column);
	assign emit_load = (state_q == S_EM_OUT) && (!rsp_valid_q || rsp.ready);

	// Configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RST;
			reduce_q  <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.addr))
				REG_MODULUS: modulus_q <= cfg.data;
				REG_REDUCE:  reduce_q  <= cfg.data[0];
				default: ;
			endcase
		end
	end
	assign p_eff = (modulus_q == '0) ? MOD_W'(1) : {1'b0, modulus_q};

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_cnt_q <= '0;
			red_cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						case (opcode_t'(cmd.opcode))
							OP_CLEAR: begin
								clr_cnt_q <= '0;
								state_q   <= S_CLEAR;
							end
							OP_SET_COEF: begin
								red_cnt_q <= '0;
								state_q   <= S_COEF;
							end
							OP_ACC: if (col_ok && sel_ok) state_q <= S_ACC_WR;
							OP_EMIT: if (col_ok) state_q <= S_EM_LD;
							default: ;
						endcase
					end
				end
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == AW'(COLS - 1)) state_q <= S_IDLE;
				end
				S_ACC_WR: state_q <= S_IDLE;
				S_EM_LD: begin
					red_cnt_q <= '0;
					state_q   <= S_EM_RED;
				end
				S_EM_RED: begin
					red_cnt_q <= red_cnt_q + 1'b1;
					if (red_cnt_q == RED_CNT_W'(RED_CYC - 1)) state_q <= S_EM_OUT;
				end
				S_EM_OUT: if (emit_load) state_q <= S_IDLE;
				S_COEF: begin
					red_cnt_q <= red_cnt_q + 1'b1;
					if (red_cnt_q == RED_CNT_W'(RED_CYC - 1)) state_q <= S_COEF_WR;
				end
				S_COEF_WR: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request fields kept for the later cycles
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			addr_q <= cmd_addr;
			col_q  <= cmd.in_column;
		end
	end

	// Lane control decode
	always_comb begin
		ctrl = '0;
		ctrl.wsel = WSEL_ZERO;
		case (state_q)
			S_IDLE: begin
				if (cmd_fire) begin
					case (opcode_t'(cmd.opcode))
						OP_SET_COEF: ctrl.red_load = 1'b1;
						OP_LOAD: begin
							ctrl.mem_we = col_ok;
							ctrl.wsel   = WSEL_VALUE;
						end
						OP_ACC:  ctrl.rd_en = col_ok && sel_ok;
						OP_EMIT: ctrl.rd_en = col_ok;
						default: ;
					endcase
				end
			end
			S_CLEAR:  ctrl.mem_we = 1'b1;
			S_ACC_WR: begin
				ctrl.mem_we = 1'b1;
				ctrl.wsel   = WSEL_SUM;
			end
			S_EM_LD: begin
				ctrl.red_load     = 1'b1;
				ctrl.red_from_mem = 1'b1;
			end
			S_EM_RED:  ctrl.red_step = 1'b1;
			S_COEF:    ctrl.red_step = 1'b1;
			S_COEF_WR: ctrl.coef_we  = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		case (state_q)
			S_IDLE:  mem_addr = cmd_addr;
			S_CLEAR: mem_addr = clr_cnt_q;
			default: mem_addr = addr_q;
		endcase
	end

	// Lanes
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		if (g < LINES) begin : g_on
			mmaa_lane #(.COLS(COLS)) u_lane (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.addr      (mem_addr),
				.value     (val[g]),
				.sel_value (sel_value),
				.p_eff     (p_eff),
				.reduce_en (reduce_q),
				.result    (lane_res[g]),
				.nonzero   (lane_nz[g])
			);
		end else begin : g_off
			assign lane_res[g] = '0;
			assign lane_nz[g]  = 1'b0;
		end
	end

	// Merge: a column goes out if any lane is nonzero
	assign any_nz = |lane_nz;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit_load) begin
			rsp_valid_q <= any_nz;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			rsp_col_q <= col_q;
			rsp_res_q <= lane_res;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.out_column = rsp_col_q;
	assign rsp.result_0   = rsp_res_q[0];
	assign rsp.result_1   = rsp_res_q[1];
	assign rsp.result_2   = rsp_res_q[2];
	assign rsp.result_3   = rsp_res_q[3];
	assign rsp.result_4   = rsp_res_q[4];
	assign rsp.result_5   = rsp_res_q[5];
	assign rsp.result_6   = rsp_res_q[6];
	assign rsp.result_7   = rsp_res_q[7];
endmodule
`default_nettype wire
